// ===== sv/dwms_pkg.sv =====
package dwms_pkg;

  // store geometry
  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_CONTAINS   = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // write request to the entry store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  // ring address of logical offset off from base
  function automatic logic [ADDR_W-1:0] ptr_add(logic [ADDR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= CAP_SUM) begin
      s = s - CAP_SUM;
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_inc(logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    r = (p == LAST_ADDR) ? '0 : p + ADDR_W'(1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] r;
    r = (p == '0) ? LAST_ADDR : p - ADDR_W'(1);
    return r;
  endfunction

endpackage

// ===== sv/dwms_ram.sv =====
module dwms_ram (
  input  logic                                clk_i,
  input  dwms_pkg::ram_wr_t                   wr_i,
  input  logic [dwms_pkg::ADDR_W-1:0]         raddr_a_i,
  input  logic [dwms_pkg::ADDR_W-1:0]         raddr_b_i,
  output logic [dwms_pkg::DATA_W-1:0]         rdata_a_o,
  output logic [dwms_pkg::DATA_W-1:0]         rdata_b_o
);

  logic [dwms_pkg::DATA_W-1:0] mem [dwms_pkg::CAPACITY];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== sv/deque_with_membership_search.sv =====
// channel   direction  ports                                    handshake
// request   in         command_i, item_value_i                  start && !busy
// result    out        status_o, found_o, front_value_o,        done_o, one cycle
//                      back_value_o, entry_count_o, is_empty_o
//
// Entries live in a ring inside a one-write, two-read synchronous RAM.
// For push, pop and unused codes the request passes through the fetch and
// done states before the strobe; contains first compares entries from the
// front up to the first match (all of them on a miss), and remove then moves
// each later entry one place forward, as the scan port reads one entry per
// cycle and the gap closing follows the match without a break.
// Reset clears the count and head pointer; no clearing pass is needed.
// The result strobe cannot be held off; a new request is taken while it shows.
module deque_with_membership_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] item_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               found_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o,
  output logic [6:0]         entry_count_o,
  output logic               is_empty_o
);

  localparam int AW = dwms_pkg::ADDR_W;
  localparam int CW = dwms_pkg::CNT_W;
  localparam int DW = dwms_pkg::DATA_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [DW-1:0] val_q, val_d;
  logic [1:0]    st_q, st_d;
  logic          fnd_q, fnd_d;
  logic          done_q;

  dwms_pkg::ram_wr_t wr;
  logic [AW-1:0]     ra, rb;
  logic [DW-1:0]     rd_a, rd_b;
  logic [CW-1:0]     idx_nx;
  logic              more;

  dwms_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .raddr_a_i (ra),
    .raddr_b_i (rb),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign busy   = (state_q != S_IDLE);
  assign idx_nx = idx_q + CW'(1);
  assign more   = (idx_nx < cnt_q);

  // sequencer and store access
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    cmd_d   = cmd_q;
    val_d   = val_q;
    st_d    = st_q;
    fnd_d   = fnd_q;
    wr      = '0;
    ra      = head_q;
    rb      = head_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = command_i;
          val_d   = item_value_i;
          st_d    = dwms_pkg::ST_OK;
          fnd_d   = 1'b0;
          state_d = S_FETCH;
          case (command_i)
            dwms_pkg::CMD_PUSH_FRONT: begin
              if (cnt_q == dwms_pkg::CAP_CNT) begin
                st_d = dwms_pkg::ST_FULL;
              end else begin
                head_d  = dwms_pkg::ptr_dec(head_q);
                wr.we   = 1'b1;
                wr.addr = dwms_pkg::ptr_dec(head_q);
                wr.data = item_value_i;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            dwms_pkg::CMD_PUSH_BACK: begin
              if (cnt_q == dwms_pkg::CAP_CNT) begin
                st_d = dwms_pkg::ST_FULL;
              end else begin
                wr.we   = 1'b1;
                wr.addr = dwms_pkg::ptr_add(head_q, cnt_q);
                wr.data = item_value_i;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            dwms_pkg::CMD_POP_FRONT: begin
              if (cnt_q == '0) begin
                st_d = dwms_pkg::ST_EMPTY;
              end else begin
                head_d = dwms_pkg::ptr_inc(head_q);
                cnt_d  = cnt_q - CW'(1);
              end
            end
            dwms_pkg::CMD_POP_BACK: begin
              if (cnt_q == '0) begin
                st_d = dwms_pkg::ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            dwms_pkg::CMD_CONTAINS, dwms_pkg::CMD_REMOVE: begin
              if (cnt_q == '0) begin
                st_d = dwms_pkg::ST_NOT_FOUND;
              end else begin
                ra      = head_q;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // rd_a holds entry idx_q
      S_SCAN: begin
        if (rd_a == val_q) begin
          fnd_d   = 1'b1;
          state_d = S_FETCH;
          if (cmd_q == dwms_pkg::CMD_REMOVE) begin
            if (more) begin
              ra      = dwms_pkg::ptr_add(head_q, idx_nx);
              idx_d   = idx_nx;
              state_d = S_SHIFT;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
        end else if (more) begin
          ra    = dwms_pkg::ptr_add(head_q, idx_nx);
          idx_d = idx_nx;
        end else begin
          st_d    = dwms_pkg::ST_NOT_FOUND;
          state_d = S_FETCH;
        end
      end
      // move entry idx_q one place toward the front
      S_SHIFT: begin
        wr.we   = 1'b1;
        wr.addr = dwms_pkg::ptr_add(head_q, idx_q - CW'(1));
        wr.data = rd_a;
        if (more) begin
          ra    = dwms_pkg::ptr_add(head_q, idx_nx);
          idx_d = idx_nx;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_FETCH;
        end
      end
      // read front and back for the result
      S_FETCH: begin
        ra      = head_q;
        rb      = (cnt_q == '0) ? head_q : dwms_pkg::ptr_add(head_q, cnt_q - CW'(1));
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= (state_q == S_DONE);
    end
  end

  // request payload and scan position
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    val_q <= val_d;
    st_q  <= st_d;
    fnd_q <= fnd_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      status_o      <= st_q;
      found_o       <= fnd_q;
      front_value_o <= (cnt_q == '0) ? '0 : rd_a;
      back_value_o  <= (cnt_q == '0) ? '0 : rd_b;
      entry_count_o <= 7'(cnt_q);
      is_empty_o    <= (cnt_q == '0);
    end
  end

  assign done_o = done_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dwms_pkg::CAP_CNT) else $error("count above capacity");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request taken without going busy");

  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_shift_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cmd_q == dwms_pkg::CMD_REMOVE && fnd_q))
    else $error("gap closing outside a matched remove");

endmodule
